// File: rtl/core/spbc_pkg.sv
`default_nettype none

package spbc_pkg;

    localparam int COORD_W          = 32;
    localparam int ZCFG_W           = 31;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 32;
    localparam int MAX_VERTICES_DEF = 8;
    localparam int MIN_POLY_VERTS   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_BALANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_Z_MIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_Z_MAX   = 2'd2;

    localparam logic [ZCFG_W-1:0] SAFE_Z_MIN_RST = 31'd0;
    localparam logic [ZCFG_W-1:0] SAFE_Z_MAX_RST = 31'd65536;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_CHECK  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LAST,
        S_LD_LAST,
        S_DIFF,
        S_MUL_P,
        S_MUL_C,
        S_CMP,
        S_FINISH,
        S_DIVX_GO,
        S_DIVX_WAIT,
        S_DIVY_GO,
        S_DIVY_WAIT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/spbc_ram.sv
`default_nettype none

module spbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/spbc_div.sv
`default_nettype none

module spbc_div #(
    parameter int SUM_W = 36,
    parameter int CNT_W = 4
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [SUM_W-1:0] i_dividend,
    input  wire logic        [CNT_W-1:0] i_divisor,
    output logic                         o_done,
    output logic signed      [SUM_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_steps;
    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic              r_neg;

    logic [CNT_W:0]    rem_sh;
    logic              fits;
    logic [CNT_W:0]    rem_sub;
    logic [SUM_W-1:0]  mag_in;

    // Restoring division of the magnitude, one quotient bit a cycle; the
    // sign is put back at the end so the result truncates toward zero.
    assign mag_in  = i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
    assign rem_sh  = {r_rem, r_q[SUM_W-1]};
    assign fits    = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_steps <= r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= mag_in;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], fits};
            r_rem <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

`default_nettype wire

// File: rtl/core/support_polygon_balance_check.sv
// Static balance checker. Requests arrive on the input channel (i_in_valid /
// o_in_ready). An append request (kind 0) stores one support vertex in a
// registered-read RAM and returns nothing; appends beyond MAX_VERTICES are
// dropped. A check request (kind 1) tests com + ref - base and the CoM itself
// against the stored polygon, produces one result on the output channel
// (o_out_valid / i_out_ready) and empties the vertex store.
// Appends keep the block idle. A check is taken only while idle, and no new
// request is accepted until its result is loaded into the output register:
// the edge loop reads one vertex per edge through the single RAM read port
// and steps each edge through difference, two products and compare on the
// two shared 33 x 35 bit cross-product multipliers. When the reference moves
// to the safe centre and n > 0, the centroid is divided out by a one-bit-a-
// cycle divider used once per axis.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready; write it only while idle.
// Reset empties the vertex store and loads the register defaults.
// If the receiver stalls, the result waits in the output register; appends
// are still taken, and a following check runs and then holds until the
// output register is free.
`default_nettype none

module support_polygon_balance_check #(
    parameter int MAX_VERTICES = spbc_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic        [spbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [spbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_kind,
    input  wire logic signed [spbc_pkg::COORD_W-1:0]  i_vertex_x,
    input  wire logic signed [spbc_pkg::COORD_W-1:0]  i_vertex_y,
    input  wire logic signed [spbc_pkg::COORD_W-1:0]  i_com_x,
    input  wire logic signed [spbc_pkg::COORD_W-1:0]  i_com_y,
    input  wire logic signed [spbc_pkg::COORD_W-1:0]  i_base_x,
    input  wire logic signed [spbc_pkg::COORD_W-1:0]  i_base_y,
    input  wire logic signed [spbc_pkg::COORD_W-1:0]  i_base_z,
    input  wire logic signed [spbc_pkg::COORD_W-1:0]  i_ref_x,
    input  wire logic signed [spbc_pkg::COORD_W-1:0]  i_ref_y,
    input  wire logic signed [spbc_pkg::COORD_W-1:0]  i_ref_z,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic                                      o_stopped,
    output logic                                      o_moved_safe,
    output logic signed      [spbc_pkg::COORD_W-1:0]  o_out_x,
    output logic signed      [spbc_pkg::COORD_W-1:0]  o_out_y,
    output logic signed      [spbc_pkg::COORD_W-1:0]  o_out_z
);

    import spbc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int SUM_W  = COORD_W + CNT_W;
    localparam int CEN_W  = SUM_W + 1;
    localparam int P_W    = COORD_W + 2;
    localparam int EX_W   = COORD_W + 1;
    localparam int D_W    = COORD_W + 3;
    localparam int PROD_W = EX_W + D_W;

    // Configuration registers
    logic              r_keep;
    logic [ZCFG_W-1:0] r_z_min;
    logic [ZCFG_W-1:0] r_z_max;

    // Control
    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_n;
    logic [ADDR_W-1:0] r_k;
    logic              r_ok_p;
    logic              r_ok_c;
    logic              r_stopped;
    logic              r_moved;
    logic              r_out_valid;

    // Request operands
    logic signed [COORD_W-1:0] r_com_x, r_com_y;
    logic signed [COORD_W-1:0] r_base_z;
    logic signed [COORD_W-1:0] r_rx, r_ry, r_rz;
    logic signed [COORD_W-1:0] r_alt_x, r_alt_y, r_alt_z;
    logic signed [P_W-1:0]     r_px, r_py;
    logic signed [EX_W-1:0]    r_bmc_x, r_bmc_y;

    // Edge loop
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic signed [EX_W-1:0]    r_ex, r_ey;
    logic signed [D_W-1:0]     r_dpx, r_dpy, r_dcx, r_dcy;
    logic signed [PROD_W-1:0]  r_pa, r_pb;
    logic signed [SUM_W-1:0]   r_sum_x, r_sum_y;
    logic signed [SUM_W-1:0]   r_qx, r_qy;

    // Output register
    logic                      r_o_stopped, r_o_moved;
    logic signed [COORD_W-1:0] r_o_x, r_o_y, r_o_z;

    logic                       in_acc;
    logic                       store_full;
    logic                       ram_we;
    logic                       ram_re;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [2*COORD_W-1:0]       ram_rdata;
    logic signed [COORD_W-1:0]  cur_x, cur_y;
    logic signed [D_W-1:0]      mul_dy, mul_dx;
    logic signed [PROD_W-1:0]   prod_a, prod_b;
    logic                       edge_last;
    logic                       enough;
    logic                       stop_now, move_now;
    logic                       div_start;
    logic signed [SUM_W-1:0]    div_dividend;
    logic                       div_done;
    logic signed [SUM_W-1:0]    div_q;
    logic                       out_free;
    logic signed [CEN_W-1:0]    cen_x, cen_y;
    logic signed [COORD_W-1:0]  sat_x, sat_y, clamp_z;
    logic signed [COORD_W:0]    z_ext;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep  <= 1'b0;
            r_z_min <= SAFE_Z_MIN_RST;
            r_z_max <= SAFE_Z_MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEEP_BALANCE: r_keep  <= i_cfg_data[0];
                CFG_SAFE_Z_MIN:   r_z_min <= i_cfg_data[ZCFG_W-1:0];
                CFG_SAFE_Z_MAX:   r_z_max <= i_cfg_data[ZCFG_W-1:0];
                default:          ;
            endcase
        end
    end

    assign in_acc     = i_in_valid && o_in_ready;
    assign store_full = r_count >= CNT_W'(MAX_VERTICES);
    assign ram_we     = in_acc && (i_kind == KIND_APPEND) && !store_full;

    spbc_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_VERTICES)
    ) u_vert_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_vertex_y, i_vertex_x}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cur_x = ram_rdata[COORD_W-1:0];
    assign cur_y = ram_rdata[2*COORD_W-1:COORD_W];

    // Both multipliers serve the shifted point first, then the CoM.
    assign mul_dy = (r_state == S_MUL_P) ? r_dpy : r_dcy;
    assign mul_dx = (r_state == S_MUL_P) ? r_dpx : r_dcx;
    assign prod_a = PROD_W'(r_ex) * PROD_W'(mul_dy);
    assign prod_b = PROD_W'(r_ey) * PROD_W'(mul_dx);

    assign edge_last = (CNT_W'(r_k) + CNT_W'(1)) == r_n;
    assign enough    = r_n >= CNT_W'(MIN_POLY_VERTS);
    assign stop_now  = !(enough && r_ok_p);
    assign move_now  = r_keep && !(enough && r_ok_c);
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_kind == KIND_CHECK)) begin
                    n_state = (r_count == '0) ? S_FINISH : S_RD_LAST;
                end
            end
            S_RD_LAST:   n_state = S_LD_LAST;
            S_LD_LAST:   n_state = S_DIFF;
            S_DIFF:      n_state = S_MUL_P;
            S_MUL_P:     n_state = S_MUL_C;
            S_MUL_C:     n_state = S_CMP;
            S_CMP:       n_state = edge_last ? S_FINISH : S_DIFF;
            S_FINISH: begin
                if (move_now && (r_n != '0)) begin
                    n_state = S_DIVX_GO;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIVX_GO:   n_state = S_DIVX_WAIT;
            S_DIVX_WAIT: n_state = div_done ? S_DIVY_GO : S_DIVX_WAIT;
            S_DIVY_GO:   n_state = S_DIVY_WAIT;
            S_DIVY_WAIT: n_state = div_done ? S_OUT : S_DIVY_WAIT;
            S_OUT:       n_state = out_free ? S_IDLE : S_OUT;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_k;
        div_start    = 1'b0;
        div_dividend = r_sum_x;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_RD_LAST: begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(r_n - CNT_W'(1));
            end
            S_LD_LAST: begin
                ram_re    = 1'b1;
                ram_raddr = r_k;
            end
            S_CMP: begin
                ram_re    = !edge_last;
                ram_raddr = r_k + ADDR_W'(1);
            end
            S_DIVX_GO: begin
                div_start    = 1'b1;
                div_dividend = r_sum_x;
            end
            S_DIVY_GO: begin
                div_start    = 1'b1;
                div_dividend = r_sum_y;
            end
            default: ;
        endcase
    end

    spbc_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_acc) begin
            if (i_kind == KIND_CHECK) begin
                r_count <= '0;
            end else if (!store_full) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n      <= r_count;
                r_k      <= '0;
                r_ok_p   <= 1'b1;
                r_ok_c   <= 1'b1;
                r_sum_x  <= '0;
                r_sum_y  <= '0;
                r_qx     <= '0;
                r_qy     <= '0;
                r_com_x  <= i_com_x;
                r_com_y  <= i_com_y;
                r_base_z <= i_base_z;
                r_rx     <= i_ref_x;
                r_ry     <= i_ref_y;
                r_rz     <= i_ref_z;
                r_alt_x  <= i_base_x;
                r_alt_y  <= i_base_y;
                r_alt_z  <= i_base_z;
                r_px     <= P_W'(i_com_x) + P_W'(i_ref_x) - P_W'(i_base_x);
                r_py     <= P_W'(i_com_y) + P_W'(i_ref_y) - P_W'(i_base_y);
                r_bmc_x  <= EX_W'(i_base_x) - EX_W'(i_com_x);
                r_bmc_y  <= EX_W'(i_base_y) - EX_W'(i_com_y);
            end
            S_LD_LAST: begin
                r_prev_x <= cur_x;
                r_prev_y <= cur_y;
            end
            S_DIFF: begin
                r_ex     <= EX_W'(cur_x) - EX_W'(r_prev_x);
                r_ey     <= EX_W'(cur_y) - EX_W'(r_prev_y);
                r_dpx    <= D_W'(r_px) - D_W'(r_prev_x);
                r_dpy    <= D_W'(r_py) - D_W'(r_prev_y);
                r_dcx    <= D_W'(r_com_x) - D_W'(r_prev_x);
                r_dcy    <= D_W'(r_com_y) - D_W'(r_prev_y);
                r_sum_x  <= r_sum_x + SUM_W'(cur_x);
                r_sum_y  <= r_sum_y + SUM_W'(cur_y);
                r_prev_x <= cur_x;
                r_prev_y <= cur_y;
            end
            S_MUL_P: begin
                r_pa <= prod_a;
                r_pb <= prod_b;
            end
            S_MUL_C: begin
                r_ok_p <= r_ok_p && (r_pa >= r_pb);
                r_pa   <= prod_a;
                r_pb   <= prod_b;
            end
            S_CMP: begin
                r_ok_c <= r_ok_c && (r_pa >= r_pb);
                r_k    <= r_k + ADDR_W'(1);
            end
            S_FINISH: begin
                r_stopped <= stop_now;
                r_moved   <= move_now;
                if (stop_now) begin
                    r_rx <= r_alt_x;
                    r_ry <= r_alt_y;
                    r_rz <= r_alt_z;
                end
            end
            S_DIVX_WAIT: begin
                if (div_done) begin
                    r_qx <= div_q;
                end
            end
            S_DIVY_WAIT: begin
                if (div_done) begin
                    r_qy <= div_q;
                end
            end
            default: ;
        endcase
    end

    // Safe centre: centroid plus (base - com), saturated to 32 bits.
    assign cen_x = CEN_W'(r_qx) + CEN_W'(r_bmc_x);
    assign cen_y = CEN_W'(r_qy) + CEN_W'(r_bmc_y);

    always_comb begin
        if ((&cen_x[CEN_W-1:COORD_W-1]) || !(|cen_x[CEN_W-1:COORD_W-1])) begin
            sat_x = cen_x[COORD_W-1:0];
        end else begin
            sat_x = cen_x[CEN_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        if ((&cen_y[CEN_W-1:COORD_W-1]) || !(|cen_y[CEN_W-1:COORD_W-1])) begin
            sat_y = cen_y[COORD_W-1:0];
        end else begin
            sat_y = cen_y[CEN_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    // The upper limit is tested first, so it wins for any height above it.
    assign z_ext = (COORD_W + 1)'(r_base_z);

    always_comb begin
        priority if (z_ext > $signed({2'b00, r_z_max})) begin
            clamp_z = {1'b0, r_z_max};
        end else if (z_ext < $signed({2'b00, r_z_min})) begin
            clamp_z = {1'b0, r_z_min};
        end else begin
            clamp_z = r_base_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_o_stopped <= r_stopped;
            r_o_moved   <= r_moved;
            r_o_x       <= r_moved ? sat_x : r_rx;
            r_o_y       <= r_moved ? sat_y : r_ry;
            r_o_z       <= r_moved ? clamp_z : r_rz;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_stopped    = r_o_stopped;
    assign o_moved_safe = r_o_moved;
    assign o_out_x      = r_o_x;
    assign o_out_y      = r_o_y;
    assign o_out_z      = r_o_z;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count above store capacity");

    a_store_empty_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_count == '0))
        else $error("vertex store not emptied while a check runs");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_n != '0))
        else $error("centroid division started with no vertices");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result appeared outside the output state");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (CNT_W'(ram_raddr) < r_n))
        else $error("vertex read beyond the stored count");

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import spbc_pkg::*;

    localparam int     RESET_CYCLES     = 11;
    localparam int     MAX_GAP          = 10;
    localparam int     LONG_HOLD_AFTER  = 60;
    localparam int     LONG_HOLD_CYCLES = 400;
    localparam int     SETTLE_CYCLES    = 20;
    localparam int     TAIL_CYCLES      = 150;
    localparam int     CYCLE_LIMIT      = 1000000;
    localparam int     PHASE_REQUESTS   = 300;
    localparam longint COORD_MAX        = 64'sd2147483647;
    localparam longint COORD_MIN        = -64'sd2147483648;
    localparam longint UNIT             = 64'sd65536;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic   kind;
        t_coord vx, vy, cx, cy, bx, by, bz, rx, ry, rz;
        logic   wait_drain;
    } t_balance_req;

    typedef struct packed {
        logic   stopped;
        logic   moved;
        t_coord x, y, z;
    } t_balance_res;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_kind      = KIND_APPEND;
    t_coord                i_vertex_x  = '0;
    t_coord                i_vertex_y  = '0;
    t_coord                i_com_x     = '0;
    t_coord                i_com_y     = '0;
    t_coord                i_base_x    = '0;
    t_coord                i_base_y    = '0;
    t_coord                i_base_z    = '0;
    t_coord                i_ref_x     = '0;
    t_coord                i_ref_y     = '0;
    t_coord                i_ref_z     = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_stopped;
    logic                  o_moved_safe;
    t_coord                o_out_x;
    t_coord                o_out_y;
    t_coord                o_out_z;

    support_polygon_balance_check uut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow of the block's registers and vertex store.
    logic              keep_mode = 1'b0;
    logic [ZCFG_W-1:0] z_floor   = SAFE_Z_MIN_RST;
    logic [ZCFG_W-1:0] z_ceiling = SAFE_Z_MAX_RST;
    longint            poly_xs[MAX_VERTICES_DEF];
    longint            poly_ys[MAX_VERTICES_DEF];
    int                poly_n    = 0;

    t_balance_req request_queue[$];
    t_balance_res expected_results[$];
    logic         drain_mark  = 1'b0;
    int           errors      = 0;
    int           cycle_count = 0;

    function automatic longint wide(t_coord v);
        return longint'(v);
    endfunction

    function automatic longint rand_coord();
        t_coord v;
        v = $urandom();
        return v;
    endfunction

    function automatic longint spread_rand(longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_coord saturate(longint v);
        if (v > COORD_MAX) return t_coord'(COORD_MAX);
        if (v < COORD_MIN) return t_coord'(COORD_MIN);
        return t_coord'(v);
    endfunction

    // A point is supported when it lies on or left of every edge, starting
    // with the closing edge from the last vertex back to the first.
    function automatic logic point_supported(longint px, longint py);
        logic signed [127:0] ex, ey, dx, dy;
        int                  prev, k;
        if (poly_n < MIN_POLY_VERTS) return 1'b0;
        prev = poly_n - 1;
        for (k = 0; k < poly_n; k++) begin
            ex = poly_xs[k] - poly_xs[prev];
            ey = poly_ys[k] - poly_ys[prev];
            dx = px - poly_xs[prev];
            dy = py - poly_ys[prev];
            if (ex * dy - ey * dx < 0) return 1'b0;
            prev = k;
        end
        return 1'b1;
    endfunction

    function automatic void track_request(t_balance_req r);
        t_balance_res res;
        longint       sum_x, sum_y, z;
        int           k;
        if (r.kind == KIND_APPEND) begin
            if (poly_n < MAX_VERTICES_DEF) begin
                poly_xs[poly_n] = wide(r.vx);
                poly_ys[poly_n] = wide(r.vy);
                poly_n++;
            end
            return;
        end
        res.stopped = 1'b0;
        res.moved   = 1'b0;
        res.x       = r.rx;
        res.y       = r.ry;
        res.z       = r.rz;
        if (!point_supported(wide(r.cx) + wide(r.rx) - wide(r.bx),
                             wide(r.cy) + wide(r.ry) - wide(r.by))) begin
            res.stopped = 1'b1;
            res.x       = r.bx;
            res.y       = r.by;
            res.z       = r.bz;
        end
        if (keep_mode && !point_supported(wide(r.cx), wide(r.cy))) begin
            sum_x = 0;
            sum_y = 0;
            for (k = 0; k < poly_n; k++) begin
                sum_x += poly_xs[k];
                sum_y += poly_ys[k];
            end
            if (poly_n > 0) begin
                sum_x = sum_x / poly_n;
                sum_y = sum_y / poly_n;
            end
            res.x = saturate(sum_x - wide(r.cx) + wide(r.bx));
            res.y = saturate(sum_y - wide(r.cy) + wide(r.by));
            z = wide(r.bz);
            if (z > longint'(z_ceiling)) z = z_ceiling;
            else if (z < longint'(z_floor)) z = z_floor;
            res.z     = t_coord'(z);
            res.moved = 1'b1;
        end
        poly_n = 0;
        expected_results.insert(expected_results.size(), res);
    endfunction

    function automatic void push_vertex(longint x, longint y);
        t_balance_req r;
        r.kind = KIND_APPEND;
        r.vx = t_coord'(x);
        r.vy = t_coord'(y);
        r.cx = $urandom();
        r.cy = $urandom();
        r.bx = $urandom();
        r.by = $urandom();
        r.bz = $urandom();
        r.rx = $urandom();
        r.ry = $urandom();
        r.rz = $urandom();
        r.wait_drain = drain_mark;
        drain_mark = 1'b0;
        request_queue.insert(request_queue.size(), r);
    endfunction

    function automatic void push_check(longint cx, longint cy, longint bx, longint by,
                                       longint bz, longint rx, longint ry, longint rz);
        t_balance_req r;
        r.kind = KIND_CHECK;
        r.vx = $urandom();
        r.vy = $urandom();
        r.cx = t_coord'(cx);
        r.cy = t_coord'(cy);
        r.bx = t_coord'(bx);
        r.by = t_coord'(by);
        r.bz = t_coord'(bz);
        r.rx = t_coord'(rx);
        r.ry = t_coord'(ry);
        r.rz = t_coord'(rz);
        r.wait_drain = drain_mark;
        drain_mark = 1'b0;
        request_queue.insert(request_queue.size(), r);
    endfunction

    function automatic longint pick_height();
        if ($urandom_range(0, 3) == 0) return rand_coord();
        return spread_rand(32'h5_0000);
    endfunction

    // Queues one polygon and its check; returns the requests that count.
    function automatic int queue_sequence();
        int     pick, n, k;
        longint ctr_x, ctr_y, rad, span, vx, vy, fx, fy, dx, dy;
        longint com_x, com_y, base_x, base_y;
        real    a0, step, dir, ang;
        pick = $urandom_range(0, 19);
        drain_mark = ($urandom_range(0, 24) == 0);
        if (pick >= 17) begin
            n = $urandom_range(0, MAX_VERTICES_DEF + 3);
            for (k = 0; k < n; k++) push_vertex(rand_coord(), rand_coord());
            push_check(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(), rand_coord());
            return (n < MAX_VERTICES_DEF ? n : MAX_VERTICES_DEF) + 1;
        end
        ctr_x = spread_rand(32'h10_0000);
        ctr_y = spread_rand(32'h10_0000);
        rad   = $urandom_range(32'h4000, 32'h4_0000);
        span  = rad * 3 / 2;
        if (pick == 14) n = $urandom_range(MAX_VERTICES_DEF + 1, MAX_VERTICES_DEF + 3);
        else n = $urandom_range(MIN_POLY_VERTS, MAX_VERTICES_DEF);
        step = 6.283185307179586 / n;
        a0   = $urandom_range(0, 6283) / 1000.0;
        // A clockwise winding leaves every point outside.
        dir  = (pick == 15) ? -1.0 : 1.0;
        dx   = spread_rand(32'h2000);
        dy   = spread_rand(32'h2000);
        if ($urandom_range(0, 3) == 0) begin
            dx = 0;
            dy = 0;
        end
        fx = ctr_x;
        fy = ctr_y;
        for (k = 0; k < n; k++) begin
            if (pick == 16) begin
                // Collinear or coincident vertices: all cross products vanish on the line.
                vx = ctr_x + k * dx;
                vy = ctr_y + k * dy;
            end else begin
                ang = a0 + dir * (k + 0.8 * $urandom_range(0, 1000) / 1000.0) * step;
                vx  = ctr_x + longint'($rtoi(rad * $cos(ang)));
                vy  = ctr_y + longint'($rtoi(rad * $sin(ang)));
            end
            if (k == 0) begin
                fx = vx;
                fy = vy;
            end
            push_vertex(vx, vy);
        end
        com_x = ctr_x + spread_rand(span);
        com_y = ctr_y + spread_rand(span);
        if (pick == 16 && $urandom_range(0, 1) == 0) begin
            k = $urandom_range(0, n - 1);
            com_x = ctr_x + k * dx;
            com_y = ctr_y + k * dy;
        end else if ($urandom_range(0, 7) == 0) begin
            com_x = fx;
            com_y = fy;
        end
        base_x = spread_rand(32'h100_0000);
        base_y = spread_rand(32'h100_0000);
        span   = $urandom_range(0, 1) ? rad / 2 : span;
        push_check(com_x, com_y, base_x, base_y, pick_height(),
                   base_x + spread_rand(span), base_y + spread_rand(span), rand_coord());
        return (n < MAX_VERTICES_DEF ? n : MAX_VERTICES_DEF) + 1;
    endfunction

    function automatic void queue_directed();
        // No vertices: outside, and the safe centre is built from the origin.
        push_check(32'h1000, -32'h2000, 3 * UNIT, 4 * UNIT, -32'h100,
                   UNIT, -UNIT, UNIT);
        // Two vertices are still too few; the centroid truncates toward zero.
        push_vertex(-3, -4);
        push_vertex(0, 1);
        push_check(UNIT, UNIT, 0, 0, 32'h10_0000, 2 * UNIT, 2 * UNIT, UNIT);
        // Both points well inside a triangle.
        push_vertex(0, 0);
        push_vertex(4 * UNIT, 0);
        push_vertex(0, 4 * UNIT);
        push_check(UNIT, UNIT, 5 * UNIT, 5 * UNIT, UNIT / 2, 5 * UNIT, 5 * UNIT, UNIT);
        // Triangle spanning the whole range with the CoM on its lower edge.
        push_vertex(COORD_MIN, COORD_MIN);
        push_vertex(COORD_MAX, COORD_MIN);
        push_vertex(COORD_MIN, COORD_MAX);
        push_check(0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                   COORD_MAX, COORD_MAX, COORD_MIN);
        // Both tests fail and the safe centre saturates on both axes.
        push_vertex(0, 0);
        push_vertex(UNIT, 0);
        push_vertex(0, UNIT);
        push_check(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                   0, 0, COORD_MAX);
        // Octagon fills the store, so the ninth vertex is dropped.
        push_vertex(2 * UNIT, 0);
        push_vertex(4 * UNIT, 0);
        push_vertex(6 * UNIT, 2 * UNIT);
        push_vertex(6 * UNIT, 4 * UNIT);
        push_vertex(4 * UNIT, 6 * UNIT);
        push_vertex(2 * UNIT, 6 * UNIT);
        push_vertex(0, 4 * UNIT);
        push_vertex(0, 2 * UNIT);
        push_vertex(-50 * UNIT, -50 * UNIT);
        push_check(UNIT / 2, UNIT / 2, UNIT, UNIT, 3 * UNIT, UNIT, UNIT, 0);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Request driver.
    t_balance_req cur_req;
    logic         req_busy   = 1'b0;
    logic         send_burst = 1'b0;
    int           send_gap   = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                track_request(cur_req);
                req_busy = 1'b0;
                send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
            end else if (!req_busy && send_gap > 0) begin
                send_gap--;
            end
            if (!req_busy && send_gap == 0 && request_queue.size() != 0) begin
                if (!request_queue[0].wait_drain || expected_results.size() == 0) begin
                    cur_req    = request_queue.pop_front();
                    req_busy   = 1'b1;
                    i_kind     <= cur_req.kind;
                    i_vertex_x <= cur_req.vx;
                    i_vertex_y <= cur_req.vy;
                    i_com_x    <= cur_req.cx;
                    i_com_y    <= cur_req.cy;
                    i_base_x   <= cur_req.bx;
                    i_base_y   <= cur_req.by;
                    i_base_z   <= cur_req.bz;
                    i_ref_x    <= cur_req.rx;
                    i_ref_y    <= cur_req.ry;
                    i_ref_z    <= cur_req.rz;
                end
            end
            i_in_valid <= req_busy;
        end
    end

    // Result monitor; one long hold-off lets the block back up and stall its input.
    int   results_seen = 0;
    int   hold_left    = 0;
    logic take_burst   = 1'b0;

    always @(posedge i_clk) begin
        t_balance_res want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %0b %0b %0d %0d %0d",
                             $time, o_stopped, o_moved_safe, o_out_x, o_out_y, o_out_z);
                end else begin
                    want = expected_results.pop_front();
                    check_field("stopped", want.stopped, o_stopped);
                    check_field("moved_safe", want.moved, o_moved_safe);
                    check_field("out_x", wide(want.x), wide(o_out_x));
                    check_field("out_y", wide(want.y), wide(o_out_y));
                    check_field("out_z", wide(want.z), wide(o_out_z));
                end
                results_seen++;
                hold_left = take_burst ? 0 : $urandom_range(0, MAX_GAP);
                if (results_seen == LONG_HOLD_AFTER) hold_left = LONG_HOLD_CYCLES;
                if ($urandom_range(0, 63) == 0) take_burst = !take_burst;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            i_out_ready <= (hold_left == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("support_polygon_balance_check test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_KEEP_BALANCE: keep_mode = data[0];
            CFG_SAFE_Z_MIN:   z_floor   = data[ZCFG_W-1:0];
            CFG_SAFE_Z_MAX:   z_ceiling = data[ZCFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || req_busy || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        int added;
        added = 0;
        while (added < count) added += queue_sequence();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] lo;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Height limits stay at their reset values for the directed requests.
        write_reg(CFG_KEEP_BALANCE, $urandom() | 32'd1);
        queue_directed();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        write_reg(CFG_SAFE_Z_MIN, 32'h0000_8000);
        write_reg(CFG_SAFE_Z_MAX, 32'h0003_0000);
        run_random(PHASE_REQUESTS);

        // Keep-balance off, height limits at the ends of their range.
        write_reg(CFG_KEEP_BALANCE, $urandom() & ~32'd1);
        write_reg(CFG_SAFE_Z_MIN, 32'h8000_0000);
        write_reg(CFG_SAFE_Z_MAX, 32'hFFFF_FFFF);
        run_random(PHASE_REQUESTS);

        // Floor above ceiling: the ceiling is applied first.
        write_reg(CFG_KEEP_BALANCE, 32'd1);
        write_reg(CFG_SAFE_Z_MIN, 32'h7FFF_FFFF);
        write_reg(CFG_SAFE_Z_MAX, 32'h8000_0000);
        write_reg(CFG_UNMAPPED, $urandom());
        run_random(PHASE_REQUESTS);

        lo = $urandom_range(0, 32'h4_0000);
        write_reg(CFG_SAFE_Z_MIN, lo);
        write_reg(CFG_SAFE_Z_MAX, lo + $urandom_range(0, 32'h4_0000));
        run_random(PHASE_REQUESTS);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("support_polygon_balance_check test passed");
        end else begin
            $display("support_polygon_balance_check test failed");
        end
        $finish;
    end

endmodule

// File: support_polygon_balance_check.f
rtl/core/spbc_pkg.sv
rtl/core/spbc_ram.sv
rtl/core/spbc_div.sv
rtl/core/support_polygon_balance_check.sv
dv/tb.sv
